// ===== rtl/tfs_pkg.sv =====
// tcp flow statistics table: shared types and codes
// no dependencies; imported by the table engine and the top level
`default_nettype none

package tfs_pkg;

  // event and query codes
  localparam logic [2:0] ACT_CONNECT    = 3'd0;
  localparam logic [2:0] ACT_SEND       = 3'd1;
  localparam logic [2:0] ACT_RECV       = 3'd2;
  localparam logic [2:0] ACT_DISCONNECT = 3'd3;
  localparam logic [2:0] ACT_QADDR      = 3'd4;
  localparam logic [2:0] ACT_QPAIR      = 3'd5;
  localparam logic [2:0] ACT_QPORT      = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam int OUT_W  = 48;
  localparam int CONN_W = 32;

  // outcome of one key search
  typedef struct packed {
    logic found;   // entry with the key exists
    logic avail;   // key absent, free slot found
  } probe_res_t;

endpackage

`default_nettype wire

// ===== rtl/tfs_in_if.sv =====
// tcp flow statistics table: event/query input channel
// valid/ready handshake with the event payload; no dependencies
`default_nettype none

interface tfs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] src_address;
  logic [31:0] dst_address;
  logic [15:0] src_port_num;
  logic [15:0] dst_port_num;
  logic [15:0] byte_count;

  modport source (output valid, action, src_address, dst_address, src_port_num,
                  dst_port_num, byte_count, input ready);
  modport sink (input valid, action, src_address, dst_address, src_port_num,
                dst_port_num, byte_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/tfs_out_if.sv =====
// tcp flow statistics table: result channel
// valid/ready handshake with status and counters; no dependencies
`default_nettype none

interface tfs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] out_total;
  logic [47:0] in_total;
  logic [31:0] conn_total;

  modport source (output valid, status, out_total, in_total, conn_total, input ready);
  modport sink (input valid, status, out_total, in_total, conn_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/tfs_table.sv =====
// tcp flow statistics table: one keyed table in a synchronous ram
// hashed linear-probe search, entry write port, clearing pass after reset; uses tfs_pkg
`default_nettype none

module tfs_table #(
  parameter int DEPTH = 256,
  parameter int KW    = 32,
  parameter int DW    = 128,
  parameter int AW    = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  output logic                     ready,
  input  wire logic                start,
  input  wire logic [KW-1:0]       key,
  input  wire logic                skip_en,
  input  wire logic [AW-1:0]       skip_idx,
  output logic                     done,
  output tfs_pkg::probe_res_t      res,
  output logic [AW-1:0]            idx,
  output logic [DW-1:0]            rdata,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_idx,
  input  wire logic [KW-1:0]       wr_key,
  input  wire logic [DW-1:0]       wr_data
);
  import tfs_pkg::*;

  localparam int EW = 1 + KW + DW;
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    T_CLR  = 4'b0001,
    T_IDLE = 4'b0010,
    T_RD   = 4'b0100,
    T_CHK  = 4'b1000
  } tstate_t;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q;

  tstate_t       state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0] key_r;
  logic          skip_en_r;
  logic [AW-1:0] skip_r;

  logic [AW-1:0] hash, hash_fix, ptr_inc;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic          hit_v, hit_k, skip_hit;

  // xor fold of the key into the index width
  always_comb begin
    hash = '0;
    for (int i = 0; i < KW; i++) begin
      hash[i % AW] = hash[i % AW] ^ key[i];
    end
    hash_fix = ({1'b0, hash} >= DEPTH_X) ? (hash - DEPTH_X[AW-1:0]) : hash;
  end

  assign ptr_inc  = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
  assign hit_v    = rd_q[EW-1];
  assign hit_k    = (rd_q[EW-2 -: KW] == key_r);
  assign skip_hit = skip_en_r && (ptr_r == skip_r);

  assign ready     = (state_r == T_IDLE);
  assign res.found = hit_v && hit_k;
  assign res.avail = !hit_v && !skip_hit;
  assign done      = (state_r == T_CHK) && (res.found || res.avail || (cnt_r == LAST));
  assign idx       = ptr_r;
  assign rdata     = rd_q[DW-1:0];

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    mem_we    = 1'b0;
    mem_wa    = wr_idx;
    mem_wd    = {1'b1, wr_key, wr_data};
    unique case (state_r)
      T_CLR: begin
        mem_we = 1'b1;
        mem_wa = ptr_r;
        mem_wd = '0;
        ptr_nxt = ptr_inc;
        if (ptr_r == LAST) begin
          state_nxt = T_IDLE;
        end
      end
      T_IDLE: begin
        mem_we = wr_en;
        if (start) begin
          ptr_nxt   = hash_fix;
          cnt_nxt   = '0;
          state_nxt = T_RD;
        end
      end
      T_RD: begin
        state_nxt = T_CHK;
      end
      T_CHK: begin
        if (done && start) begin
          // next search follows directly, as for dst right after src
          ptr_nxt   = hash_fix;
          cnt_nxt   = '0;
          state_nxt = T_RD;
        end else if (done) begin
          state_nxt = T_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          ptr_nxt   = ptr_inc;
          state_nxt = T_RD;
        end
      end
      default: state_nxt = T_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_CLR;
      ptr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state_r == T_IDLE || done)) begin
      key_r     <= key;
      skip_en_r <= skip_en;
      skip_r    <= skip_idx;
    end
  end

  // writes only come while no search runs, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[ptr_r];
  end

endmodule

`default_nettype wire

// ===== rtl/tcp_flow_statistics_table_unit.sv =====
// tcp flow statistics table: top level sequencer over address, pair and port tables
// uses tfs_pkg, tfs_in_if, tfs_out_if and three tfs_table instances
//
// in_ch carries one tcp event (connect, send, recv, disconnect) or one query;
// out_ch returns exactly one result per transfer on in_ch, in order.
// each item runs as a sequence of key searches in the tables it needs: the
// address table (src, then dst when it differs), the pair table and the port
// table; a successful event then ends with one or two write-back steps. every
// search step goes through the ram read port: address, then compare.
// in_ch.ready rises again once the result is loaded. searching a full table
// for an absent key walks all its entries.
// a finished result sits in the output register; the next item is taken
// while it waits, and its result is held until out_ch accepts the previous.
// after reset each table runs a clearing pass over all its entries, during
// which in_ch.ready stays low.
`default_nettype none

module tcp_flow_statistics_table_unit #(
  parameter int ADDR_ENTRIES = 256,
  parameter int PAIR_ENTRIES = 1024,
  parameter int PORT_ENTRIES = 4096,
  parameter int COUNT_WIDTH  = 48
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tfs_in_if.sink     in_ch,
  tfs_out_if.source  out_ch
);
  import tfs_pkg::*;

  localparam int CW  = COUNT_WIDTH;
  localparam int AAW = $clog2(ADDR_ENTRIES);
  localparam int PAW = $clog2(PAIR_ENTRIES);
  localparam int TAW = $clog2(PORT_ENTRIES);
  localparam int ADW = 2*CW + CONN_W;
  localparam int PDW = 2*CW;
  localparam int TKW = PAW + 16;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_AS   = 9'b000000010,
    S_AD   = 9'b000000100,
    S_PR   = 9'b000001000,
    S_PT   = 9'b000010000,
    S_WR1  = 9'b000100000,
    S_WR2  = 9'b001000000,
    S_DONE = 9'b010000000,
    S_HOLD = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]      act_r;
  logic [31:0]     src_r, dst_r;
  logic [15:0]     sport_r, dport_r, n_r;
  logic            same_r;
  logic [AAW-1:0]  is_r, id_r;
  logic [PAW-1:0]  ip_r;
  logic [TAW-1:0]  it_r;
  logic [ADW-1:0]  sd_r, dd_r;
  logic [PDW-1:0]  pd_r, td_r;

  logic [1:0]      hst_r;
  logic [CW-1:0]   ho_r, hr_r;
  logic [31:0]     hc_r;

  logic            out_valid_r;
  logic [1:0]      status_r;
  logic [47:0]     ot_r, itot_r;
  logic [31:0]     ct_r;

  // table handshakes
  logic a_ready, a_start, a_done, a_skip_en, a_wr;
  logic [31:0] a_key, a_wkey;
  probe_res_t a_res;
  logic [AAW-1:0] a_idx, a_widx;
  logic [ADW-1:0] a_rdata, a_wdata;

  logic p_ready, p_start, p_done, p_wr;
  logic [63:0] p_key;
  probe_res_t p_res;
  logic [PAW-1:0] p_idx;
  logic [PDW-1:0] p_rdata, p_wdata;

  logic t_ready, t_start, t_done, t_wr;
  logic [TKW-1:0] t_key;
  probe_res_t t_res;
  logic [TAW-1:0] t_idx;
  logic [PDW-1:0] t_rdata, t_wdata;

  logic        in_xfer, is_data;
  logic [31:0] po, pp;
  logic [15:0] port_k;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [15:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + (CW+1)'(b);
    return s[CW] ? '1 : s[CW-1:0];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  function automatic logic [47:0] to_out(input logic [CW-1:0] x);
    logic [63:0] e;
    e = 64'(x);
    return e[47:0];
  endfunction

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign is_data  = (act_r == ACT_SEND) || (act_r == ACT_RECV);
  assign po       = (act_r == ACT_RECV) ? dst_r : src_r;
  assign pp       = (act_r == ACT_RECV) ? src_r : dst_r;
  assign port_k   = (act_r == ACT_RECV) ? sport_r : dport_r;

  assign in_ch.ready = (state_r == S_IDLE) && a_ready && p_ready && t_ready;

  // counter updates for the write-back cycles
  logic [CW-1:0] s_sent, s_recv, d_sent, d_recv, pr_out, pr_in, tp_out, tp_in;
  logic [31:0]   s_conn, d_conn;

  always_comb begin
    s_sent = sd_r[ADW-1 -: CW];
    s_recv = sd_r[CONN_W +: CW];
    s_conn = sd_r[CONN_W-1:0];
    d_sent = dd_r[ADW-1 -: CW];
    d_recv = dd_r[CONN_W +: CW];
    d_conn = dd_r[CONN_W-1:0];
    pr_out = pd_r[PDW-1 -: CW];
    pr_in  = pd_r[CW-1:0];
    tp_out = td_r[PDW-1 -: CW];
    tp_in  = td_r[CW-1:0];
    case (act_r)
      ACT_CONNECT: begin
        s_conn = sat_inc(s_conn);
        if (same_r) begin
          s_conn = sat_inc(s_conn);
        end
        d_conn = sat_inc(d_conn);
      end
      ACT_SEND: begin
        s_sent = sat_add(s_sent, n_r);
        if (same_r) begin
          s_recv = sat_add(s_recv, n_r);
        end
        d_recv = sat_add(d_recv, n_r);
        pr_out = sat_add(pr_out, n_r);
        tp_out = sat_add(tp_out, n_r);
      end
      ACT_RECV: begin
        s_recv = sat_add(s_recv, n_r);
        if (same_r) begin
          s_sent = sat_add(s_sent, n_r);
        end
        d_sent = sat_add(d_sent, n_r);
        pr_in  = sat_add(pr_in, n_r);
        tp_in  = sat_add(tp_in, n_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    a_start   = 1'b0;
    a_key     = in_ch.src_address;
    a_skip_en = 1'b0;
    p_start   = 1'b0;
    p_key     = {po, pp};
    t_start   = 1'b0;
    t_key     = {p_idx, port_k};
    a_wr      = 1'b0;
    a_widx    = is_r;
    a_wkey    = src_r;
    a_wdata   = {s_sent, s_recv, s_conn};
    p_wr      = 1'b0;
    p_wdata   = {pr_out, pr_in};
    t_wr      = 1'b0;
    t_wdata   = {tp_out, tp_in};
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.action <= ACT_QADDR) begin
            a_start   = 1'b1;
            state_nxt = S_AS;
          end else if (in_ch.action == ACT_QPAIR || in_ch.action == ACT_QPORT) begin
            p_start   = 1'b1;
            p_key     = {in_ch.src_address, in_ch.dst_address};
            state_nxt = S_PR;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_AS: begin
        if (a_done) begin
          if (act_r == ACT_QADDR || !(a_res.found || a_res.avail)) begin
            state_nxt = S_DONE;
          end else if (same_r) begin
            if (act_r != ACT_DISCONNECT) begin
              p_start   = 1'b1;
              state_nxt = S_PR;
            end else begin
              state_nxt = S_WR1;
            end
          end else begin
            // a new src slot must not be handed out again for dst
            a_start   = 1'b1;
            a_key     = dst_r;
            a_skip_en = !a_res.found;
            state_nxt = S_AD;
          end
        end
      end
      S_AD: begin
        if (a_done) begin
          if (!(a_res.found || a_res.avail)) begin
            state_nxt = S_DONE;
          end else if (act_r != ACT_DISCONNECT) begin
            p_start   = 1'b1;
            state_nxt = S_PR;
          end else begin
            state_nxt = S_WR1;
          end
        end
      end
      S_PR: begin
        if (p_done) begin
          if (act_r == ACT_QPAIR) begin
            state_nxt = S_DONE;
          end else if (act_r == ACT_QPORT) begin
            if (p_res.found) begin
              t_start   = 1'b1;
              t_key     = {p_idx, dport_r};
              state_nxt = S_PT;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (!(p_res.found || p_res.avail)) begin
            state_nxt = S_DONE;
          end else if (act_r == ACT_CONNECT) begin
            state_nxt = S_WR1;
          end else begin
            t_start   = 1'b1;
            state_nxt = S_PT;
          end
        end
      end
      S_PT: begin
        if (t_done) begin
          if (act_r == ACT_QPORT || !(t_res.found || t_res.avail)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_WR1;
          end
        end
      end
      S_WR1: begin
        a_wr = 1'b1;
        p_wr = (act_r != ACT_DISCONNECT);
        t_wr = is_data;
        state_nxt = same_r ? S_DONE : S_WR2;
      end
      S_WR2: begin
        a_wr      = 1'b1;
        a_widx    = id_r;
        a_wkey    = dst_r;
        a_wdata   = {d_sent, d_recv, d_conn};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_HOLD && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item context, search results and the pending result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r   <= in_ch.action;
      src_r   <= in_ch.src_address;
      dst_r   <= in_ch.dst_address;
      sport_r <= in_ch.src_port_num;
      dport_r <= in_ch.dst_port_num;
      n_r     <= in_ch.byte_count;
      same_r  <= (in_ch.src_address == in_ch.dst_address);
      hst_r   <= ST_OK;
      ho_r    <= '0;
      hr_r    <= '0;
      hc_r    <= '0;
    end
    if (state_r == S_AS && a_done) begin
      is_r <= a_idx;
      id_r <= a_idx;
      sd_r <= a_res.found ? a_rdata : '0;
      dd_r <= a_res.found ? a_rdata : '0;
      if (act_r == ACT_QADDR) begin
        if (a_res.found) begin
          ho_r <= a_rdata[ADW-1 -: CW];
          hr_r <= a_rdata[CONN_W +: CW];
          hc_r <= a_rdata[CONN_W-1:0];
        end else begin
          hst_r <= ST_NOT_FOUND;
        end
      end else if (!(a_res.found || a_res.avail)) begin
        hst_r <= ST_FULL;
      end
    end
    if (state_r == S_AD && a_done) begin
      id_r <= a_idx;
      dd_r <= a_res.found ? a_rdata : '0;
      if (!(a_res.found || a_res.avail)) begin
        hst_r <= ST_FULL;
      end
    end
    if (state_r == S_PR && p_done) begin
      ip_r <= p_idx;
      pd_r <= p_res.found ? p_rdata : '0;
      if (act_r == ACT_QPAIR) begin
        if (p_res.found) begin
          ho_r <= p_rdata[PDW-1 -: CW];
          hr_r <= p_rdata[CW-1:0];
        end else begin
          hst_r <= ST_NOT_FOUND;
        end
      end else if (act_r == ACT_QPORT) begin
        if (!p_res.found) begin
          hst_r <= ST_NOT_FOUND;
        end
      end else if (!(p_res.found || p_res.avail)) begin
        hst_r <= ST_FULL;
      end
    end
    if (state_r == S_PT && t_done) begin
      it_r <= t_idx;
      td_r <= t_res.found ? t_rdata : '0;
      if (act_r == ACT_QPORT) begin
        if (t_res.found) begin
          ho_r <= t_rdata[PDW-1 -: CW];
          hr_r <= t_rdata[CW-1:0];
        end else begin
          hst_r <= ST_NOT_FOUND;
        end
      end else if (!(t_res.found || t_res.avail)) begin
        hst_r <= ST_FULL;
      end
    end
    if (state_r == S_HOLD && (!out_valid_r || out_ch.ready)) begin
      status_r <= hst_r;
      ot_r     <= to_out(ho_r);
      itot_r   <= to_out(hr_r);
      ct_r     <= hc_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.out_total  = ot_r;
  assign out_ch.in_total   = itot_r;
  assign out_ch.conn_total = ct_r;

  tfs_table #(.DEPTH(ADDR_ENTRIES), .KW(32), .DW(ADW), .AW(AAW)) u_addr (
    .clk(clk), .rst_n(rst_n), .ready(a_ready),
    .start(a_start), .key(a_key), .skip_en(a_skip_en), .skip_idx(a_idx),
    .done(a_done), .res(a_res), .idx(a_idx), .rdata(a_rdata),
    .wr_en(a_wr), .wr_idx(a_widx), .wr_key(a_wkey), .wr_data(a_wdata)
  );

  tfs_table #(.DEPTH(PAIR_ENTRIES), .KW(64), .DW(PDW), .AW(PAW)) u_pair (
    .clk(clk), .rst_n(rst_n), .ready(p_ready),
    .start(p_start), .key(p_key), .skip_en(1'b0), .skip_idx(ip_r),
    .done(p_done), .res(p_res), .idx(p_idx), .rdata(p_rdata),
    .wr_en(p_wr), .wr_idx(ip_r), .wr_key({po, pp}), .wr_data(p_wdata)
  );

  tfs_table #(.DEPTH(PORT_ENTRIES), .KW(TKW), .DW(PDW), .AW(TAW)) u_port (
    .clk(clk), .rst_n(rst_n), .ready(t_ready),
    .start(t_start), .key(t_key), .skip_en(1'b0), .skip_idx(it_r),
    .done(t_done), .res(t_res), .idx(t_idx), .rdata(t_rdata),
    .wr_en(t_wr), .wr_idx(it_r), .wr_key({ip_r, port_k}), .wr_data(t_wdata)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |->
      (ot_r == '0 && itot_r == '0 && ct_r == '0))
    else $error("failed result carries nonzero counters");

  a_addr_done: assert property (@(posedge clk) disable iff (!rst_n)
    a_done |-> (state_r == S_AS || state_r == S_AD))
    else $error("address search finished outside its step");

  a_port_done: assert property (@(posedge clk) disable iff (!rst_n)
    t_done |-> (state_r == S_PT))
    else $error("port search finished outside its step");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR1) |=> (state_r == S_WR2 || state_r == S_DONE))
    else $error("write-back sequence broken");

endmodule

`default_nettype wire
